[sv/assert_macros.svh]
// Assertion macros for the checker file, osfe_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define OSFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds across reset.
`define OSFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/osfe_pkg.sv]
// Types, constants and the CRC-4 byte step for the OOK sensor frame encoder.
// No dependencies; imported by every module of the block.
package osfe_pkg;

  localparam int SYNC_PULSES = 4;
  localparam int FRAME_W     = 40;
  localparam int SEG_COUNT   = SYNC_PULSES + 43;
  localparam int SEG_W       = $clog2(SEG_COUNT);

  localparam logic [SEG_W-1:0] SEG_GAP     = SEG_W'(0);
  localparam logic [SEG_W-1:0] SEG_START   = SEG_W'(SYNC_PULSES + 1);
  localparam logic [SEG_W-1:0] SEG_DATA_LO = SEG_W'(SYNC_PULSES + 2);
  localparam logic [SEG_W-1:0] SEG_DATA_HI = SEG_W'(SYNC_PULSES + 41);
  localparam logic [SEG_W-1:0] SEG_END     = SEG_W'(SYNC_PULSES + 42);

  localparam int CRC_BYTES = 4;
  localparam int CRC_CNT_W = $clog2(CRC_BYTES);
  localparam logic [CRC_CNT_W-1:0] CRC_LAST = CRC_CNT_W'(CRC_BYTES - 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int US_W       = 14;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 14;

  // Segment kinds
  localparam logic [2:0] KIND_GAP       = 3'd0;
  localparam logic [2:0] KIND_SYNC      = 3'd1;
  localparam logic [2:0] KIND_START_END = 3'd2;
  localparam logic [2:0] KIND_ZERO      = 3'd3;
  localparam logic [2:0] KIND_ONE       = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_GAP   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_GAP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_GAP  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED   = 4'd7;

  // Register reset values
  localparam logic [US_W-1:0] RST_PULSE_HIGH = 14'd705;   // 750 - 45
  localparam logic [US_W-1:0] RST_ZERO_GAP   = 14'd1705;  // 1750 - 45
  localparam logic [US_W-1:0] RST_ONE_GAP    = 14'd3955;  // 4000 - 45
  localparam logic [US_W-1:0] RST_START_GAP  = 14'd7705;  // 7750 - 45
  localparam logic [US_W-1:0] RST_SYNC_HIGH  = 14'd1200;
  localparam logic [US_W-1:0] RST_SYNC_LOW   = 14'd800;
  localparam logic [3:0]      RST_CRC_POLY   = 4'd3;
  localparam logic [3:0]      RST_CRC_SEED   = 4'd0;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    logic [7:0]  sensor_id;
    logic [1:0]  trend;
    logic [11:0] temperature;
    logic [7:0]  humidity_bcd;
    logic [1:0]  channel;
  } in_t;

  typedef struct packed {
    logic [US_W-1:0] on_us;
    logic [US_W-1:0] off_us;
    logic [2:0]      segment_kind;
    logic            last;
  } out_t;

  typedef struct packed {
    logic [US_W-1:0] pulse_high_us;
    logic [US_W-1:0] zero_gap_us;
    logic [US_W-1:0] one_gap_us;
    logic [US_W-1:0] start_gap_us;
    logic [US_W-1:0] sync_high_us;
    logic [US_W-1:0] sync_low_us;
    logic [3:0]      crc_poly;
    logic [3:0]      crc_seed;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // One byte of MSB-first CRC-4; the low nibble of the working byte always
  // drains to zero, so four bits of remainder carry between bytes.
  function automatic logic [3:0] crc4_byte(logic [3:0] rem, logic [7:0] data,
                                           logic [3:0] poly);
    logic [7:0] r;
    r = {rem, 4'b0000} ^ data;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ {poly, 4'b0000};
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r[7:4];
  endfunction

endpackage

[sv/osfe_front.sv]
// Front end: accepts readings, runs CRC-4 one byte per cycle, packs the frame.
// Depends on osfe_pkg; feeds osfe_fifo.
module osfe_front import osfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  input  cfg_t       cfg,
  input  fifo_stat_t stat,
  output logic       push,
  output frame_t     push_data
);

  logic                 active_r;
  logic [CRC_CNT_W-1:0] cnt_r;
  logic [3:0]           rem_r;
  in_t                  in_r;
  logic [7:0]           byte_sel;
  logic [3:0]           crc_nxt;
  logic [3:0]           crc_final;
  logic                 last_byte;
  logic                 accept;

  always_comb begin
    case (cnt_r)
      2'd0:    byte_sel = in_r.sensor_id;
      // CRC sees the channel nibble in place of the CRC nibble
      2'd1:    byte_sel = {2'b00, in_r.channel, 2'b00, in_r.trend};
      2'd2:    byte_sel = in_r.temperature[11:4];
      default: byte_sel = {in_r.temperature[3:0], in_r.humidity_bcd[7:4]};
    endcase
  end

  assign crc_nxt   = crc4_byte(rem_r, byte_sel, cfg.crc_poly);
  assign crc_final = crc_nxt ^ in_r.humidity_bcd[3:0];
  assign last_byte = (cnt_r == CRC_LAST);
  assign push      = active_r && last_byte && !stat.full;
  assign busy      = active_r && !push;
  assign accept    = start && !busy;

  assign push_data = {in_r.sensor_id, crc_final, 2'b00, in_r.trend, in_r.temperature,
                      in_r.humidity_bcd, 2'b00, in_r.channel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (accept) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r && !last_byte) begin
      cnt_r    <= cnt_r + 1'b1;
    end else if (push) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r  <= in_data;
      rem_r <= cfg.crc_seed;
    end else if (active_r && !last_byte) begin
      rem_r <= crc_nxt;
    end
  end

endmodule

[sv/osfe_fifo.sv]
// Short frame queue between front end and segment sequencer.
// Depends on osfe_pkg.
module osfe_fifo import osfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_t     push_data,
  input  logic       pop,
  output frame_t     rd_data,
  output fifo_stat_t stat
);

  frame_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  function automatic logic [FIFO_AW-1:0] ptr_inc(logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[sv/osfe_back.sv]
// Back end: walks one queued frame through its segments, one per cycle.
// Depends on osfe_pkg; drains osfe_fifo.
module osfe_back import osfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  fifo_stat_t stat,
  input  frame_t     rd_data,
  output logic       pop,
  output logic       out_valid,
  output out_t       out_data
);

  logic             active_r;
  logic [SEG_W-1:0] seg_r;
  frame_t           frame_r;
  logic             out_valid_r;
  out_t             out_r;
  out_t             seg;
  logic             in_data_seg;
  logic             seg_done;

  assign seg_done    = (seg_r == SEG_END);
  assign pop         = !stat.empty && (!active_r || seg_done);
  assign in_data_seg = (seg_r >= SEG_DATA_LO) && (seg_r <= SEG_DATA_HI);

  always_comb begin
    seg = '0;
    if (seg_r == SEG_GAP) begin
      seg.on_us        = '0;
      seg.off_us       = cfg.start_gap_us;
      seg.segment_kind = KIND_GAP;
    end else if (seg_r < SEG_START) begin
      seg.on_us        = cfg.sync_high_us;
      seg.off_us       = cfg.sync_low_us;
      seg.segment_kind = KIND_SYNC;
    end else if (in_data_seg) begin
      seg.on_us        = cfg.pulse_high_us;
      seg.off_us       = frame_r[FRAME_W-1] ? cfg.one_gap_us : cfg.zero_gap_us;
      seg.segment_kind = frame_r[FRAME_W-1] ? KIND_ONE : KIND_ZERO;
    end else begin
      seg.on_us        = cfg.pulse_high_us;
      seg.off_us       = cfg.start_gap_us;
      seg.segment_kind = KIND_START_END;
      seg.last         = seg_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
      if (pop) begin
        active_r <= 1'b1;
        seg_r    <= '0;
      end else if (active_r) begin
        active_r <= !seg_done;
        seg_r    <= seg_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= seg;
    if (pop) begin
      frame_r <= rd_data;
    end else if (active_r && in_data_seg) begin
      frame_r <= {frame_r[FRAME_W-2:0], 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[sv/ook_sensor_frame_encoder_core.sv]
// Top level of the OOK pulse-distance sensor frame encoder.
// Depends on osfe_pkg, osfe_front, osfe_fifo and osfe_back.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-----------------------------------
//  input   | start, busy, in_data           | taken when start && !busy
//  result  | out_valid, out_data            | valid per segment, no back-pressure
//  config  | cfg_valid, cfg_ready,          | written when cfg_valid && cfg_ready
//          | cfg_index, cfg_data            | (cfg_ready is always high)
//
// A reading runs through the front end one CRC-4 byte per cycle, then waits in
// a two-frame queue. The back-end sequencer emits SYNC_PULSES + 43 segments
// (47) at one per cycle; that sequencer sets the sustained reading rate. With
// the queue empty, a frame goes on to the back end, whose first segment leaves
// through its output register. Reset is synchronous, active low, and restores
// register defaults at once; no clearing pass. busy rises only while the front
// end holds a finished frame against a full queue or is mid-CRC.
module ook_sensor_frame_encoder_core import osfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg_r;
  logic       push;
  logic       pop;
  frame_t     push_data;
  frame_t     rd_data;
  fifo_stat_t stat;

  assign cfg_ready = 1'b1;

  // Register file: keep the low bits of each write, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_high_us <= RST_PULSE_HIGH;
      cfg_r.zero_gap_us   <= RST_ZERO_GAP;
      cfg_r.one_gap_us    <= RST_ONE_GAP;
      cfg_r.start_gap_us  <= RST_START_GAP;
      cfg_r.sync_high_us  <= RST_SYNC_HIGH;
      cfg_r.sync_low_us   <= RST_SYNC_LOW;
      cfg_r.crc_poly      <= RST_CRC_POLY;
      cfg_r.crc_seed      <= RST_CRC_SEED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PULSE_HIGH: cfg_r.pulse_high_us <= cfg_data;
        REG_ZERO_GAP:   cfg_r.zero_gap_us   <= cfg_data;
        REG_ONE_GAP:    cfg_r.one_gap_us    <= cfg_data;
        REG_START_GAP:  cfg_r.start_gap_us  <= cfg_data;
        REG_SYNC_HIGH:  cfg_r.sync_high_us  <= cfg_data;
        REG_SYNC_LOW:   cfg_r.sync_low_us   <= cfg_data;
        REG_CRC_POLY:   cfg_r.crc_poly      <= cfg_data[3:0];
        REG_CRC_SEED:   cfg_r.crc_seed      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Accept readings and build the CRC-protected frame.
  osfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple front end from segment sequencer.
  osfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .stat      (stat)
  );

  // Emit gap, sync, start, data and end segments.
  osfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .stat      (stat),
    .rd_data   (rd_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sv/osfe_checker.sv]
// Port-level checks on the encoder's segment stream, bound to the top level.
// Depends on osfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module osfe_checker import osfe_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input out_t out_data
);

  // Drop the strobe right after reset.
  `OSFE_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "strobe after reset")

  // The leading gap carries no carrier.
  `OSFE_ASSERT(a_gap_off, clk, rst_n, out_valid && out_data.segment_kind == KIND_GAP |-> out_data.on_us == '0, "gap with carrier")

  // A gap is always followed at once by a sync pulse.
  `OSFE_ASSERT(a_gap_sync, clk, rst_n, out_valid && out_data.segment_kind == KIND_GAP |=> out_valid && out_data.segment_kind == KIND_SYNC, "gap not followed by sync")

  // The final segment is an end pulse, followed by silence or a new gap.
  `OSFE_ASSERT(a_last_end, clk, rst_n, out_valid && out_data.last |=> !out_valid || out_data.segment_kind == KIND_GAP, "bad segment after last")

endmodule

bind ook_sensor_frame_encoder_core osfe_checker u_osfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data)
);
